// File: hw/rtl/conv33_pkg.sv
package conv33_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT    = 4096;
	localparam int MIN_DIM       = 3;

	localparam int PIX_W   = 8;
	localparam int ROW_W   = 12;
	localparam int COL_W   = 10;
	localparam int WREG_W  = 11;
	localparam int HREG_W  = 13;
	localparam int CLAMP_W = 13;
	localparam int KROW_W  = 48;
	localparam int COEF_W  = 16;
	localparam int KDIM    = 3;
	localparam int CFG_IDX_W = 3;

	localparam int PROD_W = COEF_W + PIX_W + 1;
	localparam int RSUM_W = PROD_W + 2;
	localparam int SUM_W  = RSUM_W + 2;
	localparam int FRAC_W = 8;
	localparam int Q_W    = SUM_W - FRAC_W;

	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 8;
	localparam int MID_LVL_W = $clog2(MID_DEPTH + 1);
	localparam int OUT_LVL_W = $clog2(OUT_DEPTH + 1);

	localparam logic [WREG_W-1:0] WIDTH_RST  = WREG_W'(1024);
	localparam logic [HREG_W-1:0] HEIGHT_RST = HREG_W'(480);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_KERNEL_TOP   = 3'd2,
		REG_KERNEL_MID   = 3'd3,
		REG_KERNEL_BOT   = 3'd4
	} reg_idx_t;

	typedef logic [KDIM-1:0][KDIM-1:0][PIX_W-1:0] window_t;
	typedef logic [KDIM-1:0][KROW_W-1:0] kernel_t;

	typedef struct packed {
		window_t          win;
		logic             inner;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} job_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_pixel;
		logic [ROW_W-1:0] out_row;
		logic [COL_W-1:0] out_col;
	} res_t;

endpackage

// File: hw/rtl/conv33_fifo.sv
module conv33_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [WIDTH-1:0]               wdata,
	input  logic                           pop,
	output logic [WIDTH-1:0]               rdata,
	output logic                           empty,
	output logic [$clog2(DEPTH+1)-1:0]     level
);
	localparam int AW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [LW-1:0]    level_q;
	logic             do_pop;

	assign empty  = (level_q == '0);
	assign do_pop = pop && !empty;
	assign rdata  = mem_q[rd_ptr_q];
	assign level  = level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (push && !do_pop) begin
				level_q <= level_q + LW'(1);
			end else if (!push && do_pop) begin
				level_q <= level_q - LW'(1);
			end
		end
	end

endmodule

// File: hw/rtl/conv33_front.sv
module conv33_front #(
	parameter int MAX_WIDTH = conv33_pkg::MAX_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  logic [conv33_pkg::PIX_W-1:0]        pixel,
	input  logic                                frame_start,
	output logic                                full,
	input  logic [conv33_pkg::WREG_W-1:0]       image_width,
	input  logic [conv33_pkg::HREG_W-1:0]       image_height,
	input  logic [conv33_pkg::MID_LVL_W-1:0]    mid_level,
	output logic                                job_push,
	output conv33_pkg::job_t                    job
);
	import conv33_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = CW + 1;

	logic [CLAMP_W-1:0] w_ext;
	logic [WW-1:0]      w_eff;
	logic [HREG_W-1:0]  h_eff;

	logic [CW-1:0]      col_q;
	logic [ROW_W-1:0]   row_q;
	logic [CW-1:0]      cc;
	logic [ROW_W-1:0]   rc;
	logic [WW-1:0]      cc_inc;
	logic [HREG_W-1:0]  rc_inc;
	logic               wrap_col;
	logic               wrap_row;
	logic               accept;

	logic               emit;
	logic [ROW_W-1:0]   orow;
	logic [WW-1:0]      ocol;
	logic               inner;

	logic               valid_s1;
	logic [PIX_W-1:0]   pix_s1;
	logic [CW-1:0]      col_s1;
	logic               emit_s1;
	logic               inner_s1;
	logic [ROW_W-1:0]   orow_s1;
	logic [COL_W-1:0]   ocol_s1;
	logic [2*PIX_W-1:0] rd_s1;
	logic               fwd_s1;
	logic [2*PIX_W-1:0] fwd_data_s1;

	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [2*PIX_W-1:0] line_eff;
	logic [2*PIX_W-1:0] wr_word;

	window_t            win_q;
	window_t            win_next;

	// clamp dimensions
	assign w_ext = CLAMP_W'(image_width);
	assign w_eff = (w_ext < CLAMP_W'(MIN_DIM))   ? WW'(MIN_DIM) :
	               (w_ext > CLAMP_W'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(w_ext);
	assign h_eff = (image_height < HREG_W'(MIN_DIM))    ? HREG_W'(MIN_DIM) :
	               (image_height > HREG_W'(MAX_HEIGHT)) ? HREG_W'(MAX_HEIGHT) : image_height;

	assign full   = ((MID_LVL_W+1)'(mid_level) + (MID_LVL_W+1)'(valid_s1))
	                >= (MID_LVL_W+1)'(MID_DEPTH);
	assign accept = push && !full;

	assign cc       = frame_start ? '0 : col_q;
	assign rc       = frame_start ? '0 : row_q;
	assign cc_inc   = WW'(cc) + WW'(1);
	assign rc_inc   = HREG_W'(rc) + HREG_W'(1);
	assign wrap_col = cc_inc >= w_eff;
	assign wrap_row = rc_inc >= h_eff;

	// classify the output position this word produces
	assign emit  = (rc >= ROW_W'(2)) || ((rc == ROW_W'(1)) && (cc != '0));
	assign orow  = (cc == '0) ? rc - ROW_W'(2) : rc - ROW_W'(1);
	assign ocol  = (cc == '0) ? w_eff - WW'(1) : WW'(cc) - WW'(1);
	assign inner = (orow != '0) && ((HREG_W'(orow) + HREG_W'(2)) <= h_eff) &&
	               (ocol != '0) && (((WW+1)'(ocol) + (WW+1)'(2)) <= (WW+1)'(w_eff));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (wrap_col) begin
					col_q <= '0;
					row_q <= wrap_row ? '0 : rc_inc[ROW_W-1:0];
				end else begin
					col_q <= cc_inc[CW-1:0];
					row_q <= rc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= pixel;
			col_s1      <= cc;
			emit_s1     <= emit;
			inner_s1    <= inner;
			orow_s1     <= orow;
			ocol_s1     <= COL_W'(ocol);
			rd_s1       <= line_mem[cc];
			fwd_s1      <= valid_s1 && (col_s1 == cc);
			fwd_data_s1 <= wr_word;
		end
	end

	assign line_eff = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign wr_word  = {line_eff[PIX_W-1:0], pix_s1};

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			line_mem[col_s1] <= wr_word;
		end
	end

	always_comb begin
		for (int r = 0; r < KDIM; r++) begin
			win_next[r][0] = win_q[r][1];
			win_next[r][1] = win_q[r][2];
		end
		win_next[0][2] = line_eff[2*PIX_W-1:PIX_W];
		win_next[1][2] = line_eff[PIX_W-1:0];
		win_next[2][2] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (valid_s1) begin
			win_q <= win_next;
		end
	end

	assign job_push  = valid_s1 && emit_s1;
	assign job.win   = win_next;
	assign job.inner = inner_s1;
	assign job.row   = orow_s1;
	assign job.col   = ocol_s1;

endmodule

// File: hw/rtl/conv33_mac.sv
module conv33_mac (
	input  logic                             clk,
	input  logic                             arst_n,
	input  conv33_pkg::job_t                 job,
	input  logic                             job_empty,
	output logic                             job_pop,
	input  conv33_pkg::kernel_t              kernel,
	input  logic [conv33_pkg::OUT_LVL_W-1:0] out_level,
	output logic                             res_push,
	output conv33_pkg::res_t                 res
);
	import conv33_pkg::*;

	localparam int CRW = OUT_LVL_W + 2;

	logic                     valid_s1;
	logic                     valid_s2;
	logic                     valid_s3;
	logic signed [PROD_W-1:0] prod_s1 [KDIM][KDIM];
	logic signed [RSUM_W-1:0] rsum_s2 [KDIM];
	logic signed [SUM_W-1:0]  sum_s3;
	logic                     inner_s1, inner_s2, inner_s3;
	logic [ROW_W-1:0]         row_s1, row_s2, row_s3;
	logic [COL_W-1:0]         col_s1, col_s2, col_s3;

	logic [Q_W-1:0]           q;
	logic [FRAC_W-1:0]        rem;
	logic                     up;
	logic [Q_W:0]             qr;
	logic [PIX_W-1:0]         sat;

	// hold off the queue unless the output queue can take everything in flight
	assign job_pop = !job_empty &&
	                 ((CRW'(out_level) + CRW'(valid_s1) + CRW'(valid_s2) + CRW'(valid_s3))
	                  < CRW'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= job_pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			for (int r = 0; r < KDIM; r++) begin
				for (int c = 0; c < KDIM; c++) begin
					prod_s1[r][c] <= $signed(kernel[r][(KDIM-1-c)*COEF_W +: COEF_W]) *
					                 $signed({1'b0, job.win[r][c]});
				end
			end
			inner_s1 <= job.inner;
			row_s1   <= job.row;
			col_s1   <= job.col;
		end
		if (valid_s1) begin
			for (int r = 0; r < KDIM; r++) begin
				rsum_s2[r] <= RSUM_W'(prod_s1[r][0]) + RSUM_W'(prod_s1[r][1]) +
				              RSUM_W'(prod_s1[r][2]);
			end
			inner_s2 <= inner_s1;
			row_s2   <= row_s1;
			col_s2   <= col_s1;
		end
		if (valid_s2) begin
			sum_s3   <= SUM_W'(rsum_s2[0]) + SUM_W'(rsum_s2[1]) + SUM_W'(rsum_s2[2]);
			inner_s3 <= inner_s2;
			row_s3   <= row_s2;
			col_s3   <= col_s2;
		end
	end

	// round half to even, then clamp to the pixel range
	always_comb begin
		q   = sum_s3[SUM_W-1:FRAC_W];
		rem = sum_s3[FRAC_W-1:0];
		up  = (rem > FRAC_W'(128)) || ((rem == FRAC_W'(128)) && q[0]);
		qr  = {q[Q_W-1], q} + (Q_W+1)'(up);
		if (qr[Q_W]) begin
			sat = '0;
		end else if (qr[Q_W-1:PIX_W] != '0) begin
			sat = '1;
		end else begin
			sat = qr[PIX_W-1:0];
		end
	end

	assign res_push      = valid_s3;
	assign res.out_pixel = inner_s3 ? sat : '0;
	assign res.out_row   = row_s3;
	assign res.out_col   = col_s3;

endmodule

// File: hw/rtl/conv2d_3x3_u8_unit.sv
// 3x3 convolution of 8-bit grey pixels streamed in raster order, one pixel per
// clock sustained while full stays low. Each accepted pixel at linear index k of
// a frame produces the result for position k-W-1; no result comes for the first
// W+1 pixels of a frame, and border positions give 0. A pixel's result reaches
// the output queue via the line-store read register, the job queue, then three
// arithmetic stages (products, row sums, total with rounding). full rises only
// when the output queue and the job queue behind it have backed up under pop
// stalls. The user must write registers only while the block is idle; the block
// does not enforce this. Width and height clamp to 3..MAX_WIDTH and 3..4096.
module conv2d_3x3_u8_unit #(
	parameter int MAX_WIDTH = conv33_pkg::MAX_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [conv33_pkg::PIX_W-1:0]        pixel,
	input  logic                                frame_start,
	output logic                                empty,
	input  logic                                pop,
	output logic [conv33_pkg::PIX_W-1:0]        out_pixel,
	output logic [conv33_pkg::ROW_W-1:0]        out_row,
	output logic [conv33_pkg::COL_W-1:0]        out_col,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [conv33_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [conv33_pkg::KROW_W-1:0]       cfg_data
);
	import conv33_pkg::*;

	logic [WREG_W-1:0]    width_q;
	logic [HREG_W-1:0]    height_q;
	kernel_t              kernel_q;

	logic                 job_push;
	job_t                 job_in;
	job_t                 job_out;
	logic                 job_empty;
	logic                 job_pop;
	logic [MID_LVL_W-1:0] mid_level;

	logic                 res_push;
	res_t                 res_in;
	res_t                 res_out;
	logic [OUT_LVL_W-1:0] out_level;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			kernel_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q     <= cfg_data[WREG_W-1:0];
				REG_IMAGE_HEIGHT: height_q    <= cfg_data[HREG_W-1:0];
				REG_KERNEL_TOP:   kernel_q[0] <= cfg_data;
				REG_KERNEL_MID:   kernel_q[1] <= cfg_data;
				REG_KERNEL_BOT:   kernel_q[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	conv33_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.pixel        (pixel),
		.frame_start  (frame_start),
		.full         (full),
		.image_width  (width_q),
		.image_height (height_q),
		.mid_level    (mid_level),
		.job_push     (job_push),
		.job          (job_in)
	);

	conv33_fifo #(
		.WIDTH($bits(job_t)),
		.DEPTH(MID_DEPTH)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_in),
		.pop    (job_pop),
		.rdata  (job_out),
		.empty  (job_empty),
		.level  (mid_level)
	);

	conv33_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job_out),
		.job_empty (job_empty),
		.job_pop   (job_pop),
		.kernel    (kernel_q),
		.out_level (out_level),
		.res_push  (res_push),
		.res       (res_in)
	);

	conv33_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(OUT_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty),
		.level  (out_level)
	);

	assign out_pixel = res_out.out_pixel;
	assign out_row   = res_out.out_row;
	assign out_col   = res_out.out_col;

endmodule

// File: bench/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import conv33_pkg::*;

	localparam int LINE_DEPTH   = MAX_WIDTH_DEF;
	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 12;
	localparam int PRINT_LIMIT  = 40;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic [PIX_W-1:0]     pixel;
	logic                 frame_start;
	logic                 empty;
	logic                 pop;
	logic [PIX_W-1:0]     out_pixel;
	logic [ROW_W-1:0]     out_row;
	logic [COL_W-1:0]     out_col;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [KROW_W-1:0]    cfg_data;

	conv2d_3x3_u8_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.pixel       (pixel),
		.frame_start (frame_start),
		.empty       (empty),
		.pop         (pop),
		.out_pixel   (out_pixel),
		.out_row     (out_row),
		.out_col     (out_col),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	logic [WREG_W-1:0] width_reg;
	logic [HREG_W-1:0] height_reg;
	logic [KROW_W-1:0] kernel_rows [KDIM];
	logic [PIX_W-1:0]  line_upper [LINE_DEPTH];
	logic [PIX_W-1:0]  line_lower [LINE_DEPTH];
	logic [PIX_W-1:0]  win [KDIM][KDIM];
	int unsigned       row_cnt;
	int unsigned       col_cnt;

	res_t   expected_pixels [$];
	bit     calm;
	int     pop_hold_left;
	int     pop_idle_left;
	int     errors;
	int     pixels_sent;
	int     results_checked;
	longint cycles;

	always #6 clk = ~clk;

	function automatic bit filter_pixel(input logic [PIX_W-1:0] pix, input bit fs,
			output res_t res);
		int w, h, col, orow, ocol, r, c;
		longint acc, q, rem;
		logic [COEF_W-1:0] k;
		bit emit;
		w = width_reg;
		if (w < MIN_DIM) w = MIN_DIM;
		if (w > LINE_DEPTH) w = LINE_DEPTH;
		h = height_reg;
		if (h < MIN_DIM) h = MIN_DIM;
		if (h > MAX_HEIGHT) h = MAX_HEIGHT;
		if (fs) begin
			row_cnt = 0;
			col_cnt = 0;
		end
		col = col_cnt % LINE_DEPTH;
		for (r = 0; r < KDIM; r++) begin
			win[r][0] = win[r][1];
			win[r][1] = win[r][2];
		end
		win[0][2] = line_upper[col];
		win[1][2] = line_lower[col];
		win[2][2] = pix;
		line_upper[col] = line_lower[col];
		line_lower[col] = pix;

		res = '0;
		emit = (row_cnt >= 2) || (row_cnt == 1 && col_cnt >= 1);
		if (emit) begin
			if (col_cnt == 0) begin
				orow = row_cnt - 2;
				ocol = w - 1;
			end else begin
				orow = row_cnt - 1;
				ocol = col_cnt - 1;
			end
			if (orow >= 1 && orow + 2 <= h && ocol >= 1 && ocol + 2 <= w) begin
				acc = 0;
				for (r = 0; r < KDIM; r++) begin
					for (c = 0; c < KDIM; c++) begin
						k = kernel_rows[r][KROW_W-1-COEF_W*c -: COEF_W];
						acc += longint'($signed(k)) * longint'(win[r][c]);
					end
				end
				// round half to even, then clamp to the pixel range
				q = acc >>> 8;
				rem = acc & 255;
				if (rem > 128 || (rem == 128 && q[0]))
					q++;
				if (q < 0)
					q = 0;
				if (q > 255)
					q = 255;
				res.out_pixel = q[PIX_W-1:0];
			end
			res.out_row = orow[ROW_W-1:0];
			res.out_col = ocol[COL_W-1:0];
		end

		if (col_cnt + 1 >= w) begin
			col_cnt = 0;
			if (row_cnt + 1 >= h)
				row_cnt = 0;
			else
				row_cnt++;
		end else begin
			col_cnt++;
		end
		return emit;
	endfunction

	function automatic logic [KROW_W-1:0] kernel_row(input int left, input int mid,
			input int right);
		return {COEF_W'(left), COEF_W'(mid), COEF_W'(right)};
	endfunction

	function automatic logic [KROW_W-1:0] random_kernel();
		if ($urandom_range(0, 3) == 0)
			return KROW_W'({$urandom(), $urandom()});
		return kernel_row(int'($urandom_range(0, 512)) - 256,
			int'($urandom_range(0, 512)) - 256, int'($urandom_range(0, 512)) - 256);
	endfunction

	function automatic logic [PIX_W-1:0] random_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= PRINT_LIMIT)
			$display("mismatch at cycle %0d: %s", cycles, msg);
	endtask

	task automatic send_pixel(input logic [PIX_W-1:0] pix, input bit fs);
		res_t res;
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		push <= 1'b1;
		pixel <= pix;
		frame_start <= fs;
		do @(posedge clk); while (full);
		pixels_sent++;
		if (filter_pixel(pix, fs, res))
			expected_pixels.insert(expected_pixels.size(), res);
	endtask

	task automatic wait_drain;
		@(negedge clk);
		push <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [KROW_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_IMAGE_WIDTH:  width_reg = val[WREG_W-1:0];
			REG_IMAGE_HEIGHT: height_reg = val[HREG_W-1:0];
			REG_KERNEL_TOP:   kernel_rows[0] = val;
			REG_KERNEL_MID:   kernel_rows[1] = val;
			REG_KERNEL_BOT:   kernel_rows[2] = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_frame(input int w, input int h, input logic [KROW_W-1:0] k_top,
			input logic [KROW_W-1:0] k_mid, input logic [KROW_W-1:0] k_bot);
		wait_drain;
		write_reg(REG_IMAGE_WIDTH, KROW_W'(w));
		write_reg(REG_IMAGE_HEIGHT, KROW_W'(h));
		write_reg(REG_KERNEL_TOP, k_top);
		write_reg(REG_KERNEL_MID, k_mid);
		write_reg(REG_KERNEL_BOT, k_bot);
	endtask

	task automatic test_rounding_ties;
		logic [PIX_W-1:0] mid_row [5];
		int i;
		mid_row = '{8'd7, 8'd3, 8'd5, 8'd255, 8'd9};
		// height below the minimum clamps to 3; half weight on the center tap
		set_frame(5, 2, '0, kernel_row(0, 128, 0), '0);
		for (i = 0; i < 15; i++)
			send_pixel((i / 5 == 1) ? mid_row[i % 5] : random_pixel(), i == 0);
	endtask

	task automatic test_saturation;
		logic [PIX_W-1:0] sat_pixels [18];
		int i;
		sat_pixels = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0,
			8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0};
		// second frame follows by row wrap, no frame_start
		set_frame(1, 3, kernel_row(32767, 32767, 32767),
			kernel_row(-32768, -32768, -32768), kernel_row(32767, 0, -32768));
		for (i = 0; i < 18; i++)
			send_pixel(sat_pixels[i], i == 0);
	endtask

	task automatic test_random_frames(input int budget);
		int w, h, ew, n, i, sent;
		bit keep_width;
		sent = 0;
		w = MIN_DIM;
		while (sent < budget) begin
			// keeping the width lets the frame run on, even past a lowered height
			keep_width = (sent > 0) && ($urandom_range(0, 3) == 0);
			if (!keep_width) begin
				case ($urandom_range(0, 5))
					0: w = $urandom_range(0, 2);
					1: w = $urandom_range(17, 80);
					default: w = $urandom_range(3, 16);
				endcase
			end
			h = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
			set_frame(w, h, random_kernel(), random_kernel(), random_kernel());
			ew = (w < MIN_DIM) ? MIN_DIM : w;
			n = ew * $urandom_range(2, 10) + $urandom_range(0, ew);
			if (n > 400)
				n = 400;
			if (n > budget - sent)
				n = budget - sent;
			for (i = 0; i < n; i++)
				send_pixel(random_pixel(), (i == 0 && !keep_width) || $urandom_range(0, 99) == 0);
			sent += n;
		end
	endtask

	task automatic test_backpressure;
		int i;
		set_frame(4, 5, random_kernel(), random_kernel(), random_kernel());
		// hold pop low so the block fills up and stalls incoming words
		pop_hold_left = 300;
		for (i = 0; i < 200; i++)
			send_pixel(random_pixel(), i == 0);
		wait_drain;
	endtask

	task automatic test_streaming;
		int i;
		set_frame(7, 6, random_kernel(), random_kernel(), random_kernel());
		calm = 1'b1;
		for (i = 0; i < 200; i++)
			send_pixel(random_pixel(), i == 0);
	endtask

	always @(negedge clk) begin
		if (pop_hold_left > 0) begin
			pop_hold_left--;
			pop <= 1'b0;
		end else if (pop_idle_left > 0) begin
			pop_idle_left--;
			pop <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			pop_idle_left = $urandom_range(0, 4);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_result
		res_t want;
		if (arst_n && pop && !empty) begin
			results_checked++;
			if (expected_pixels.size() == 0) begin
				report_mismatch($sformatf("unexpected result pixel %0d row %0d col %0d",
					out_pixel, out_row, out_col));
			end else begin
				want = expected_pixels.pop_front();
				if (out_pixel !== want.out_pixel)
					report_mismatch($sformatf("out_pixel %0d, expected %0d (row %0d col %0d)",
						out_pixel, want.out_pixel, want.out_row, want.out_col));
				if (out_row !== want.out_row)
					report_mismatch($sformatf("out_row %0d, expected %0d",
						out_row, want.out_row));
				if (out_col !== want.out_col)
					report_mismatch($sformatf("out_col %0d, expected %0d",
						out_col, want.out_col));
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, expected_pixels.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		pixel = '0;
		frame_start = 1'b0;
		pop = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_data = '0;
		calm = 1'b0;
		width_reg = WIDTH_RST;
		height_reg = HEIGHT_RST;
		kernel_rows = '{default: '0};
		line_upper = '{default: '0};
		line_lower = '{default: '0};
		win = '{default: '{default: '0}};
		row_cnt = 0;
		col_cnt = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_rounding_ties;
		test_saturation;
		test_random_frames(750);
		test_backpressure;
		test_streaming;
		wait_drain;

		$display("%0d pixels in, %0d results checked, %0d mismatches",
			pixels_sent, results_checked, errors);
		$display("rounding ties, saturation, clamped sizes, row wrap and mid-frame restarts,");
		$display("long pop stalls that fill the block, gap-free streaming at the end");
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: conv2d_3x3_u8_unit.f
hw/rtl/conv33_pkg.sv
hw/rtl/conv33_fifo.sv
hw/rtl/conv33_front.sv
hw/rtl/conv33_mac.sv
hw/rtl/conv2d_3x3_u8_unit.sv
bench/tb.sv
